/* hw/rtl/bbcm_pkg.sv */
// Shared types and codes for the block buffer cache manager.
package bbcm_pkg;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_DIRTY   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        IO_NONE  = 2'd0,
        IO_READ  = 2'd1,
        IO_WRITE = 2'd2
    } t_io;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_FULL     = 2'd1,
        ERR_UNDERRUN = 2'd2,
        ERR_OVERFLOW = 2'd3
    } t_err;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_DIRTY_OP,
        ST_REL,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_RC_SCAN,
        ST_RC_CHK,
        ST_RC_PUSH,
        ST_POP,
        ST_POP_RD,
        ST_ALLOC,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] device_id;
        logic [31:0] block_number;
        logic [5:0]  buffer_index;
    } t_in_beat;

    typedef struct packed {
        logic [5:0]  result_index;
        logic        hit;
        logic [1:0]  io_kind;
        logic [15:0] io_device;
        logic [34:0] io_sector;
        logic [15:0] count_after;
        logic [1:0]  error_code;
    } t_out_beat;

endpackage

/* hw/rtl/bbcm_ram.sv */
// Generic single-port RAM with registered read.
module bbcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* hw/rtl/block_buffer_cache_manager_core.sv */
// Block buffer cache manager top level: sequencer over buffer entry memories.
// An unknown op, or a release or mark dirty with an index past the pool, goes straight to the result;
// mark dirty and release read the entry first, and a release that writes back also forms the sector;
// a get scans the entries one by one and, on a miss, pops the free stack, refilled by reclaim when empty.
// One beat at a time: the next is accepted only after the result beat is taken.
// Reset: synchronous active low; marks, free stack top and stamp counter come back at once.
module block_buffer_cache_manager_core
    import bbcm_pkg::*;
#(
    parameter int NUM_BUFFERS       = 64,
    parameter int SECTORS_PER_BLOCK = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);
    localparam int IW = $clog2(NUM_BUFFERS);
    localparam int CW = $clog2(NUM_BUFFERS + 1);

    t_state r_state, n_state;

    // Flip-flop state per buffer: cached, dirty, reclaim taken. Counts live in a RAM;
    // an uncached buffer's count is masked to zero on read, so the RAM needs no clearing.
    logic [NUM_BUFFERS-1:0] r_cached, n_cached;
    logic [NUM_BUFFERS-1:0] r_dirty, n_dirty;
    logic [NUM_BUFFERS-1:0] r_taken, n_taken;
    logic                   cnt_we;
    logic [IW-1:0]          cnt_addr;
    logic [15:0]            cnt_wdata, cnt_rdata;

    logic [CW-1:0] r_top, n_top;
    logic [31:0]   r_ins, n_ins;
    logic [CW-1:0] r_fill, n_fill;   // free stack entries ever written past reset

    t_in_beat  r_req, n_req;
    t_out_beat r_out, n_out;
    logic      r_ovalid, n_ovalid;

    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_best, n_best;
    logic [31:0]   r_bage, n_bage;
    logic          r_found, n_found;
    logic [35:0]   r_prod, n_prod;

    // Entry memories: tag (device, block, stamp) and free stack
    logic            tag_we;
    logic [IW-1:0]   tag_addr;
    logic [79:0]     tag_wdata, tag_rdata;
    logic            fs_we;
    logic [IW-1:0]   fs_addr;
    logic [IW-1:0]   fs_wdata, fs_rdata;

    bbcm_ram #(.WIDTH(80), .DEPTH(NUM_BUFFERS)) u_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_addr(tag_addr),
        .i_wdata(tag_wdata), .o_rdata(tag_rdata)
    );
    bbcm_ram #(.WIDTH(IW), .DEPTH(NUM_BUFFERS)) u_fs (
        .i_clk(i_clk), .i_we(fs_we), .i_addr(fs_addr),
        .i_wdata(fs_wdata), .o_rdata(fs_rdata)
    );
    bbcm_ram #(.WIDTH(16), .DEPTH(NUM_BUFFERS)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_addr(cnt_addr),
        .i_wdata(cnt_wdata), .o_rdata(cnt_rdata)
    );

    logic [15:0] tag_dev;
    logic [31:0] tag_blk, tag_stamp, age;
    logic [IW-1:0] req_bi;
    logic [15:0]   cur_cnt;
    logic          last;

    assign tag_dev   = tag_rdata[79:64];
    assign tag_blk   = tag_rdata[63:32];
    assign tag_stamp = tag_rdata[31:0];
    assign age       = r_ins - tag_stamp;
    assign req_bi    = IW'(r_req.buffer_index);
    // count of entry r_idx, read the cycle before alongside its tag
    assign cur_cnt   = r_cached[r_idx] ? cnt_rdata : 16'd0;
    assign last      = 32'(r_idx) == 32'(NUM_BUFFERS - 1);

    assign o_stall = (r_state != ST_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cached <= '0;
            r_dirty  <= '0;
            r_top    <= CW'(NUM_BUFFERS);
            r_fill   <= '0;
            r_ins    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cached <= n_cached;
            r_dirty  <= n_dirty;
            r_top    <= n_top;
            r_fill   <= n_fill;
            r_ins    <= n_ins;
            r_ovalid <= n_ovalid;
        end
        r_taken <= n_taken;
        r_req   <= n_req;
        r_out   <= n_out;
        r_idx   <= n_idx;
        r_best  <= n_best;
        r_bage  <= n_bage;
        r_found <= n_found;
        r_prod  <= n_prod;
    end

    always_comb begin
        n_state   = r_state;
        n_cached  = r_cached;
        n_dirty   = r_dirty;
        n_taken   = r_taken;
        n_top     = r_top;
        n_fill    = r_fill;
        n_ins     = r_ins;
        n_req     = r_req;
        n_out     = r_out;
        n_ovalid  = r_ovalid;
        n_idx     = r_idx;
        n_best    = r_best;
        n_bage    = r_bage;
        n_found   = r_found;
        n_prod    = r_prod;
        cnt_we    = 1'b0;
        cnt_addr  = r_idx;
        cnt_wdata = '0;
        tag_we    = 1'b0;
        tag_addr  = r_idx;
        tag_wdata = {r_req.device_id, r_req.block_number, r_ins};
        fs_we     = 1'b0;
        fs_addr   = r_top[IW-1:0];
        fs_wdata  = r_best;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_req = i_data;
                    n_idx = '0;
                    n_out = '0;
                    n_out.result_index = i_data.buffer_index;
                    if (t_op'(i_data.operation) == OP_GET) begin
                        n_state = ST_SCAN;
                    end else if (t_op'(i_data.operation) == OP_NONE ||
                                 {26'd0, i_data.buffer_index} >= 32'(NUM_BUFFERS)) begin
                        n_state = ST_OUT;
                    end else begin
                        n_idx   = IW'(i_data.buffer_index);
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                // tag and count reads for req_bi issued at r_idx
                if (t_op'(r_req.operation) == OP_DIRTY) begin
                    n_state = ST_DIRTY_OP;
                end else begin
                    n_state = ST_REL;
                end
            end
            ST_DIRTY_OP: begin
                n_dirty[req_bi]   = 1'b1;
                n_out.count_after = cur_cnt;
                n_state           = ST_OUT;
            end
            ST_REL: begin
                if (cur_cnt == '0) begin
                    n_out.error_code = ERR_UNDERRUN;
                    n_state          = ST_OUT;
                end else begin
                    cnt_we    = 1'b1;
                    cnt_addr  = req_bi;
                    cnt_wdata = cur_cnt - 16'd1;
                    if (cur_cnt == 16'd1 && r_dirty[req_bi]) begin
                        n_dirty[req_bi] = 1'b0;
                        n_out.io_kind   = IO_WRITE;
                        n_out.io_device = tag_dev;
                        n_prod          = 36'(tag_blk) * 36'(SECTORS_PER_BLOCK);
                        n_state         = ST_MUL;
                    end else begin
                        n_out.count_after = cur_cnt - 16'd1;
                        n_state           = ST_OUT;
                    end
                end
            end
            ST_SCAN: begin
                n_state = ST_SCAN_CHK;   // read of entry r_idx in flight
            end
            ST_SCAN_CHK: begin
                if (r_cached[r_idx] && tag_dev == r_req.device_id &&
                    tag_blk == r_req.block_number) begin
                    n_out.result_index = 6'(r_idx);
                    n_out.hit          = 1'b1;
                    if (cur_cnt == 16'hFFFF) begin
                        n_out.error_code  = ERR_OVERFLOW;
                        n_out.count_after = cur_cnt;
                    end else begin
                        cnt_we            = 1'b1;
                        cnt_wdata         = cur_cnt + 16'd1;
                        n_out.count_after = cur_cnt + 16'd1;
                    end
                    n_state = ST_OUT;
                end else if (!last) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_SCAN;
                end else begin
                    n_out.result_index = '0;
                    n_taken            = '0;
                    n_idx              = '0;
                    n_found            = 1'b0;
                    n_state            = (r_top == '0) ? ST_RC_SCAN : ST_POP;
                end
            end
            ST_RC_SCAN: begin
                n_state = ST_RC_CHK;
            end
            ST_RC_CHK: begin
                // pick the youngest reclaimable entry, lowest index on ties
                if (r_cached[r_idx] && cur_cnt == '0 && !r_taken[r_idx] &&
                    (!r_found || age < r_bage)) begin
                    n_best  = r_idx;
                    n_bage  = age;
                    n_found = 1'b1;
                end
                if (!last) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_RC_SCAN;
                end else begin
                    n_state = ST_RC_PUSH;
                end
            end
            ST_RC_PUSH: begin
                if (!r_found || r_top >= CW'(NUM_BUFFERS)) begin
                    n_state = ST_POP;
                end else begin
                    n_taken[r_best]  = 1'b1;
                    n_cached[r_best] = 1'b0;
                    fs_we            = 1'b1;
                    n_top            = r_top + 1'b1;
                    if (r_top >= r_fill) begin
                        n_fill = r_top + 1'b1;
                    end
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = ST_RC_SCAN;
                end
            end
            ST_POP: begin
                if (r_top == '0) begin
                    n_out.error_code = ERR_FULL;
                    n_state          = ST_OUT;
                end else begin
                    n_top   = r_top - 1'b1;
                    n_state = ST_POP_RD;
                end
            end
            ST_POP_RD: begin
                fs_addr = r_top[IW-1:0];
                n_state = ST_ALLOC;
            end
            ST_ALLOC: begin
                // unwritten stack slots are not read; their own index i is used in their place
                n_idx = (r_top < r_fill) ? fs_rdata : r_top[IW-1:0];
                tag_addr = n_idx;
                tag_we   = 1'b1;
                cnt_we   = 1'b1;
                cnt_addr = n_idx;
                cnt_wdata = 16'd1;
                n_cached[n_idx]    = 1'b1;
                n_ins              = r_ins + 32'd1;
                n_out.result_index = 6'(n_idx);
                n_out.io_kind      = IO_READ;
                n_out.io_device    = r_req.device_id;
                n_out.count_after  = 16'd1;
                n_prod  = 36'(r_req.block_number) * 36'(SECTORS_PER_BLOCK);
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_out.io_sector = r_prod[34:0];
                n_state         = ST_OUT;
            end
            ST_OUT: begin
                n_ovalid = 1'b1;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= CW'(NUM_BUFFERS)) else $error("free stack top out of range");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(NUM_BUFFERS)) else $error("fill count out of range");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("ready while busy");
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> o_valid) else $error("result not raised");
`endif
endmodule

/* sim/testbench.sv */
// Self-checking testbench for the block buffer cache manager core.
`timescale 1ns / 1ps

module testbench;
    import bbcm_pkg::*;

    localparam int NBUF = 64;
    localparam int SPB  = 2;

    // Buffer pool mirror: predicts every result beat and holds the expected queue.
    class pool_scoreboard;
        bit          cached[NBUF];
        logic [15:0] dev_of[NBUF];
        logic [31:0] blk_of[NBUF];
        logic [15:0] refs[NBUF];
        bit          dirty[NBUF];
        logic [31:0] stamp[NBUF];
        int          free_stk[NBUF];
        int          free_top;
        logic [31:0] stamp_ctr;
        t_out_beat   pending[$];
        int          mismatches;

        function new();
            for (int i = 0; i < NBUF; i++) begin
                cached[i] = 0; refs[i] = 0; dirty[i] = 0;
                dev_of[i] = 0; blk_of[i] = 0; stamp[i] = 0;
                free_stk[i] = i;
            end
            free_top = NBUF;
            stamp_ctr = 0;
            mismatches = 0;
        endfunction

        // Push idle cached buffers, youngest first, so the oldest ends on top.
        function void reclaim_idle();
            bit taken[NBUF];
            int best;
            logic [31:0] best_age, age;
            for (int i = 0; i < NBUF; i++) taken[i] = 0;
            forever begin
                best = -1;
                best_age = 0;
                for (int i = 0; i < NBUF; i++) begin
                    if (cached[i] && refs[i] == 0 && !taken[i]) begin
                        age = stamp_ctr - stamp[i];
                        if (best < 0 || age < best_age) begin
                            best = i; best_age = age;
                        end
                    end
                end
                if (best < 0 || free_top >= NBUF) break;
                taken[best] = 1;
                cached[best] = 0;
                free_stk[free_top] = best;
                free_top++;
            end
        endfunction

        function void note_request(t_in_beat b);
            t_out_beat r;
            int idx;
            r = '0;
            idx = b.buffer_index;
            if (b.operation == OP_GET) begin
                for (int i = 0; i < NBUF; i++) begin
                    if (cached[i] && dev_of[i] == b.device_id && blk_of[i] == b.block_number) begin
                        r.result_index = 6'(i);
                        r.hit = 1'b1;
                        if (refs[i] == 16'hFFFF) r.error_code = ERR_OVERFLOW;
                        else refs[i]++;
                        r.count_after = refs[i];
                        pending.push_back(r);
                        return;
                    end
                end
                if (free_top == 0) reclaim_idle();
                if (free_top == 0) begin
                    r.error_code = ERR_FULL;
                    pending.push_back(r);
                    return;
                end
                free_top--;
                idx = free_stk[free_top];
                cached[idx] = 1;
                refs[idx] = 16'd1;
                dev_of[idx] = b.device_id;
                blk_of[idx] = b.block_number;
                stamp[idx] = stamp_ctr;
                stamp_ctr++;
                r.result_index = 6'(idx);
                r.io_kind = IO_READ;
                r.io_device = b.device_id;
                r.io_sector = 35'(b.block_number) * 35'(SPB);
                r.count_after = 16'd1;
            end else begin
                r.result_index = b.buffer_index;
                if (b.operation == OP_RELEASE && idx < NBUF) begin
                    if (refs[idx] == 0) begin
                        r.error_code = ERR_UNDERRUN;
                    end else begin
                        refs[idx]--;
                        r.count_after = refs[idx];
                        if (refs[idx] == 0 && dirty[idx]) begin
                            dirty[idx] = 0;
                            r.io_kind = IO_WRITE;
                            r.io_device = dev_of[idx];
                            r.io_sector = 35'(blk_of[idx]) * 35'(SPB);
                        end
                    end
                end else if (b.operation == OP_DIRTY && idx < NBUF) begin
                    dirty[idx] = 1;
                    r.count_after = refs[idx];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.result_index !== want.result_index || got.hit !== want.hit ||
                got.io_kind !== want.io_kind || got.io_device !== want.io_device ||
                got.io_sector !== want.io_sector || got.count_after !== want.count_after ||
                got.error_code !== want.error_code) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    t_in_beat  req_beat;
    logic      rsp_valid;
    logic      rsp_stall;
    t_out_beat rsp_beat;

    pool_scoreboard sb;
    bit             stall_random;

    block_buffer_cache_manager_core #(.NUM_BUFFERS(NBUF), .SECTORS_PER_BLOCK(SPB)) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (req_valid),
        .o_stall (req_stall),
        .i_data  (req_beat),
        .o_valid (rsp_valid),
        .i_stall (rsp_stall),
        .o_data  (rsp_beat)
    );

    always begin
        clk = 1'b1; #10;
        clk = 1'b0; #10;
    end

    // Check each result beat accepted at a rising edge.
    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall) sb.check_result(rsp_beat);
    end

    // Receiver stall: mostly short random stalls, with periods of no stall at all.
    always @(posedge clk) begin
        if (!rst_n || !stall_random) begin
            rsp_stall <= 1'b0;
        end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Hold one request beat until accepted, then drop valid if a gap follows.
    task automatic send_request(t_in_beat b, bit keep_valid);
        req_beat  <= b;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        sb.note_request(b);
        if (!keep_valid) req_valid <= 1'b0;
    endtask

    // Apply each beat as part of a burst, with a random gap after each burst.
    int burst_left = 0;
    task automatic issue(t_in_beat b);
        bit more;
        int gap;
        if (burst_left == 0) burst_left = $urandom_range(1, 12);
        burst_left--;
        more = (burst_left != 0);
        gap = more ? 0 : $urandom_range(0, 6);
        send_request(b, gap == 0);
        repeat (gap) @(posedge clk);
    endtask

    function automatic t_in_beat mk(t_op op, logic [15:0] dev, logic [31:0] blk,
                                    logic [5:0] bi);
        t_in_beat b;
        b.operation = op;
        b.device_id = dev;
        b.block_number = blk;
        b.buffer_index = bi;
        return b;
    endfunction

    // Pick a get from a small working set so hits, reclaims and pool-full occur.
    function automatic t_in_beat rand_get();
        if ($urandom_range(0, 9) == 0)
            return mk(OP_GET, 16'($urandom), $urandom, 6'($urandom));
        return mk(OP_GET, 16'($urandom_range(0, 3)), $urandom_range(0, 40), 6'($urandom));
    endfunction

    function automatic t_in_beat rand_beat();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return rand_get();
        if (k < 85) return mk(OP_RELEASE, 16'($urandom), $urandom, 6'($urandom));
        if (k < 97) return mk(OP_DIRTY, 16'($urandom), $urandom, 6'($urandom));
        return mk(OP_NONE, 16'($urandom), $urandom, 6'($urandom));
    endfunction

    initial begin
        #2_000_000_000;
        $display("block_buffer_cache_manager_core test failed");
        $finish;
    end

    initial begin
        int drain;
        sb = new();
        stall_random = 0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_beat  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, each operation, write back, underflow, odd codes.
        issue(mk(OP_GET, 16'hFFFF, 32'hFFFF_FFFF, 6'h3F));
        issue(mk(OP_GET, 16'h0000, 32'h0000_0000, 6'h00));
        issue(mk(OP_GET, 16'hFFFF, 32'hFFFF_FFFF, 6'h00));
        issue(mk(OP_DIRTY, 16'hFFFF, 32'hFFFF_FFFF, 6'd63));
        issue(mk(OP_RELEASE, 16'h0, 32'h0, 6'd63));
        issue(mk(OP_RELEASE, 16'h0, 32'h0, 6'd63));
        issue(mk(OP_RELEASE, 16'h0, 32'h0, 6'd63));
        issue(mk(OP_RELEASE, 16'h0, 32'h0, 6'd0));
        issue(mk(OP_DIRTY, 16'h0, 32'h0, 6'd5));
        issue(mk(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, 6'h3F));
        issue(mk(OP_NONE, 16'h0, 32'h0, 6'h00));

        // Fill the pool, overrun it, then release a few to force reclaim order.
        for (int i = 0; i < 64; i++) issue(mk(OP_GET, 16'h7, 32'(i + 100), 6'd0));
        issue(mk(OP_GET, 16'h8, 32'd1, 6'd0));
        for (int i = 10; i < 14; i++) issue(mk(OP_DIRTY, 16'h0, 32'h0, 6'(i)));
        for (int i = 10; i < 20; i++) issue(mk(OP_RELEASE, 16'h0, 32'h0, 6'(i)));
        for (int i = 0; i < 12; i++) issue(mk(OP_GET, 16'h9, 32'(i), 6'd0));

        stall_random = 1;
        for (int n = 0; n < 1950; n++) begin
            if (n == 1200) stall_random = 0;
            if (n == 1500) stall_random = 1;
            issue(rand_beat());
        end
        req_valid <= 1'b0;

        drain = 0;
        while (sb.pending.size() != 0 && drain < 200_000) begin
            @(posedge clk);
            drain++;
        end
        repeat (300) @(posedge clk);

        if (sb.pending.size() == 0 && sb.mismatches == 0) begin
            $display("block_buffer_cache_manager_core test passed");
        end else begin
            $display("block_buffer_cache_manager_core test failed");
        end
        $finish;
    end

endmodule

/* block_buffer_cache_manager_core.f */
hw/rtl/bbcm_pkg.sv
hw/rtl/bbcm_ram.sv
hw/rtl/block_buffer_cache_manager_core.sv
sim/testbench.sv
